// ===== src/pdot_pkg.sv =====
`default_nettype none

package pdot_pkg;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned LABEL_W = 8;
    localparam int unsigned ID_W    = 6;
    localparam int unsigned RAD_W   = 23;
    localparam int unsigned IN_W    = 56;
    localparam int unsigned OUT_W   = 64;
    localparam int unsigned USER_W  = 2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd256;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PRIME,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/pdot_store.sv =====
`default_nettype none

module pdot_store
    import pdot_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/proximity_dedup_object_table.sv =====
// Proximity de-duplicating object table.
// A detection request arrives on the slave stream (s_tdata holds x, y and the
// class label). The block walks every stored entry through one memory read
// port, one entry per cycle, looking for an entry of the same label whose x
// and y both lie strictly within the safety radius of the detection. If none
// matches, the detection is appended at the next free slot, or flagged as
// dropped when the table is full. The whole table is then sent on the master
// stream, oldest entry first, with m_tlast on the final entry and the
// added/dropped flags in m_tuser on every entry.
// Steps: the request is taken while idle, the stored entries are scanned through
// the single read port of the entry memory, the match is decided and any append
// is written, the read port is primed, and the entries are then emitted in turn.
// Only one request is in work at a time; s_tready is high only while idle.
// When m_tready is low the current entry is held and the walk pauses.
// The user must write the radius register on the configuration channel only
// while idle; the block itself does not enforce it.
// Reset empties the table and sets the radius to 1.0; no clearing pass runs.

`default_nettype none

module proximity_dedup_object_table
    import pdot_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [RAD_W-1:0]  i_cfg_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // pos_x, pos_y, class_label
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // entry_x, entry_y, entry_label, entry_id, pad
    output logic [USER_W-1:0]      m_tuser,   // was_added, was_dropped
    output logic                   m_tlast
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_state             r_state, n_state;
    logic [RAD_W-1:0]   r_radius;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_cmp_v, n_cmp_v;
    logic               r_found, n_found;
    logic               r_added, n_added;
    logic               r_dropped, n_dropped;
    t_entry             r_probe;
    logic               r_ovalid, n_ovalid;
    t_entry             r_oentry;
    logic [ID_W-1:0]    r_oid;
    logic               r_oadded, r_odropped, r_olast;

    logic               we;
    logic [AW-1:0]      raddr;
    t_entry             rdata;
    t_entry             probe_in;
    logic               load_now;
    logic               hit;
    logic               is_last;
    logic [CW-1:0]      idx_inc;
    logic signed [COORD_W:0] dx, dy, rad_s;

    pdot_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_probe),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign probe_in.x     = s_tdata[COORD_W-1:0];
    assign probe_in.y     = s_tdata[2*COORD_W-1:COORD_W];
    assign probe_in.label = s_tdata[2*COORD_W+LABEL_W-1:2*COORD_W];

    assign dx    = $signed({rdata.x[COORD_W-1], rdata.x})
                 - $signed({r_probe.x[COORD_W-1], r_probe.x});
    assign dy    = $signed({rdata.y[COORD_W-1], rdata.y})
                 - $signed({r_probe.y[COORD_W-1], r_probe.y});
    assign rad_s = $signed({2'b00, r_radius});
    assign hit   = (rdata.label == r_probe.label)
                 && (dx < rad_s) && (dx > -rad_s)
                 && (dy < rad_s) && (dy > -rad_s);

    assign idx_inc = r_idx + 1'b1;
    assign is_last = (idx_inc == r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_count && !r_cmp_v) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_PRIME;
            end
            ST_PRIME: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (load_now && is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = (r_state == ST_IDLE);
        load_now  = (r_state == ST_EMIT) && (!r_ovalid || m_tready);
        we        = 1'b0;
        raddr     = r_idx[AW-1:0];
        n_idx     = r_idx;
        n_cmp_v   = 1'b0;
        n_found   = r_found;
        n_count   = r_count;
        n_added   = r_added;
        n_dropped = r_dropped;
        n_ovalid  = r_ovalid && !m_tready;
        unique case (r_state)
            ST_IDLE: begin
                n_idx   = '0;
                n_found = 1'b0;
            end
            ST_SCAN: begin
                if (r_idx != r_count) begin
                    n_idx   = idx_inc;
                    n_cmp_v = 1'b1;
                end
                if (r_cmp_v && hit) begin
                    n_found = 1'b1;
                end
            end
            ST_DECIDE: begin
                n_added   = 1'b0;
                n_dropped = 1'b0;
                if (!r_found) begin
                    if (r_count < CW'(TABLE_DEPTH)) begin
                        we      = 1'b1;
                        n_count = r_count + 1'b1;
                        n_added = 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            ST_PRIME: begin
                raddr = '0;
                n_idx = '0;
            end
            ST_EMIT: begin
                if (load_now) begin
                    raddr    = idx_inc[AW-1:0];
                    n_idx    = idx_inc;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_radius  <= RADIUS_RESET;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_v   <= 1'b0;
            r_found   <= 1'b0;
            r_added   <= 1'b0;
            r_dropped <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_v   <= n_cmp_v;
            r_found   <= n_found;
            r_added   <= n_added;
            r_dropped <= n_dropped;
            r_ovalid  <= n_ovalid;
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_probe <= probe_in;
        end
        if (load_now) begin
            r_oentry   <= rdata;
            r_oid      <= ID_W'(r_idx[AW-1:0]);
            r_oadded   <= r_added;
            r_odropped <= r_dropped;
            r_olast    <= is_last;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_ovalid;
    assign m_tdata     = {2'b00, r_oid, r_oentry.label, r_oentry.y, r_oentry.x};
    assign m_tuser     = {r_odropped, r_oadded};
    assign m_tlast     = r_olast;

endmodule

`default_nettype wire

// ===== src/pdot_checker.sv =====
`default_nettype none

module pdot_checker
    import pdot_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_W-1:0]  m_tdata,
    input wire logic [USER_W-1:0] m_tuser,
    input wire logic              m_tlast
);

    // A stalled entry stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output entry withdrawn while stalled");

    // A stalled entry keeps its contents.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output entry changed while stalled");

    // One request is worked on at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // A detection is never both appended and dropped.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("added and dropped both set");

    // No new request is taken before the table run reaches its last entry.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a table run");

endmodule

bind proximity_dedup_object_table pdot_checker u_pdot_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/dedup_table_checker.sv =====
module dedup_table_checker
    import pdot_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [RAD_W-1:0]  i_cfg_data,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [IN_W-1:0]   i_s_tdata,   // pos_x, pos_y, class_label
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [OUT_W-1:0]  i_m_tdata,   // entry_x, entry_y, entry_label, entry_id, pad
    input  wire logic [USER_W-1:0] i_m_tuser,   // was_added, was_dropped
    input  wire logic              i_m_tlast,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct {
        t_entry          body;
        logic [ID_W-1:0] id;
        logic            added;
        logic            dropped;
        logic            last;
    } t_table_row;

    logic [RAD_W-1:0] radius;
    t_entry           stored_rows [TABLE_DEPTH];
    int unsigned      stored_count;
    t_table_row       rows_due [$];
    int               mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report(input string field, input longint unsigned got,
                          input longint unsigned want);
        $display("mismatch on %s: got %0h, expected %0h", field, got, want);
        mismatch_count++;
    endtask

    // A detection matches a stored entry of the same label when both axis
    // distances lie strictly inside the radius, taken at full precision.
    task automatic predict_table(input logic [IN_W-1:0] det);
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [LABEL_W-1:0]        lab;
        longint                    r;
        longint                    dx;
        longint                    dy;
        bit                        hit;
        bit                        added;
        bit                        dropped;
        t_table_row                row;
        px = det[COORD_W-1:0];
        py = det[2*COORD_W-1:COORD_W];
        lab = det[IN_W-1:2*COORD_W];
        r = longint'(radius);
        hit = 1'b0;
        added = 1'b0;
        dropped = 1'b0;
        for (int i = 0; i < stored_count; i++) begin
            dx = longint'($signed(stored_rows[i].x)) - longint'(px);
            dy = longint'($signed(stored_rows[i].y)) - longint'(py);
            if (stored_rows[i].label == lab && dx < r && dx > -r && dy < r && dy > -r) begin
                hit = 1'b1;
            end
        end
        if (!hit) begin
            if (stored_count < TABLE_DEPTH) begin
                stored_rows[stored_count].x = px;
                stored_rows[stored_count].y = py;
                stored_rows[stored_count].label = lab;
                stored_count++;
                added = 1'b1;
            end else begin
                dropped = 1'b1;
            end
        end
        for (int i = 0; i < stored_count; i++) begin
            row.body = stored_rows[i];
            row.id = ID_W'(i);
            row.added = added;
            row.dropped = dropped;
            row.last = (i + 1 == stored_count);
            rows_due = {rows_due, row};
        end
    endtask

    task automatic check_row();
        t_table_row want;
        if (rows_due.size() == 0) begin
            report("entry with nothing due", i_m_tdata, 0);
        end else begin
            want = rows_due.pop_front();
            if (i_m_tdata[COORD_W-1:0] != want.body.x)
                report("entry_x", i_m_tdata[COORD_W-1:0], want.body.x);
            if (i_m_tdata[2*COORD_W-1:COORD_W] != want.body.y)
                report("entry_y", i_m_tdata[2*COORD_W-1:COORD_W], want.body.y);
            if (i_m_tdata[IN_W-1:2*COORD_W] != want.body.label)
                report("entry_label", i_m_tdata[IN_W-1:2*COORD_W], want.body.label);
            if (i_m_tdata[IN_W+ID_W-1:IN_W] != want.id)
                report("entry_id", i_m_tdata[IN_W+ID_W-1:IN_W], want.id);
            if (i_m_tuser[0] != want.added)
                report("was_added", i_m_tuser[0], want.added);
            if (i_m_tuser[1] != want.dropped)
                report("was_dropped", i_m_tuser[1], want.dropped);
            if (i_m_tlast != want.last)
                report("last_entry", i_m_tlast, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radius = RADIUS_RESET;
            stored_count = 0;
            rows_due.delete();
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_row();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                radius = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_table(i_s_tdata);
            end
            o_pending <= rows_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import pdot_pkg::*;

    localparam int unsigned DEPTH       = 64;
    localparam int          COORD_MAX   = 8388607;
    localparam int          COORD_MIN   = -8388608;
    localparam int unsigned RADIUS_MAX  = 8388607;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 20;
    localparam int          PHASE_ITEMS = 97;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [RAD_W-1:0]  i_cfg_data  = '0;
    logic              s_tvalid    = 1'b0;
    logic [IN_W-1:0]   s_tdata     = '0;
    logic              m_tready    = 1'b0;
    logic              o_cfg_ready;
    logic              s_tready;
    logic              m_tvalid;
    logic [OUT_W-1:0]  m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic              m_tlast;

    int          fail_count;
    int          pending;
    int          send_idle = 8;
    int          recv_idle = 83;
    int          quiet_cycles = 0;
    int unsigned radius_now = 256;
    int          hist_x [$];
    int          hist_y [$];
    int          hist_lab [$];

    proximity_dedup_object_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    dedup_table_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end else if (v < COORD_MIN) begin
            return COORD_MIN;
        end
        return int'(v);
    endfunction

    task automatic send_detection(input int px, input int py, input int lab);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {lab[LABEL_W-1:0], py[COORD_W-1:0], px[COORD_W-1:0]};
        do @(posedge i_clk); while (!s_tready);
        hist_x = {hist_x, px};
        hist_y = {hist_y, py};
        hist_lab = {hist_lab, lab};
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_radius(input int unsigned r);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= r[RAD_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radius_now = r;
    endtask

    // Most requests land close to an earlier detection so that matches,
    // near misses and boundary distances all occur; the rest are fresh.
    task automatic send_random_detection();
        int px;
        int py;
        int lab;
        int k;
        int span;
        if (hist_x.size() > 0 && $urandom_range(99) < 55) begin
            k = $urandom_range(hist_x.size() - 1);
            span = (radius_now > 65536) ? 65536 : int'(radius_now) + 1;
            px = clamp_coord(longint'(hist_x[k]) + longint'($urandom_range(2 * span)) - span);
            py = clamp_coord(longint'(hist_y[k]) + longint'($urandom_range(2 * span)) - span);
            lab = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : hist_lab[k];
        end else begin
            px = int'($urandom) >>> 8;
            py = int'($urandom) >>> 8;
            lab = ($urandom_range(99) < 30) ? int'($urandom_range(255)) :
                                              int'($urandom_range(3));
        end
        send_detection(px, py, lab);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_radius(256);
        send_detection(COORD_MAX, COORD_MAX, 255);
        send_detection(COORD_MAX, COORD_MAX, 255);
        send_detection(COORD_MAX - 255, COORD_MAX - 255, 255);
        send_detection(COORD_MAX - 256, COORD_MAX, 255);
        send_detection(COORD_MIN, COORD_MIN, 0);
        send_detection(COORD_MIN, COORD_MIN, 1);
        send_detection(COORD_MIN + 255, COORD_MIN + 255, 0);
        send_detection(COORD_MIN, COORD_MIN + 256, 0);
        send_detection(0, 0, 128);
        send_detection(-1, -1, 128);

        write_radius(0);
        send_detection(0, 0, 128);
        send_detection(0, 0, 128);

        write_radius(RADIUS_MAX);
        send_detection(COORD_MIN, COORD_MIN, 255);
        send_detection(COORD_MAX, COORD_MIN, 255);
        send_detection(0, 0, 255);
        send_detection(1, 1, 255);
        send_detection(5592405, -5592406, 85);
        send_detection(-5592406, 5592405, 170);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 8;
                    recv_idle = 83;
                    write_radius($urandom_range(4096, 1));
                end
                1: begin
                    send_idle = 83;
                    recv_idle = 8;
                    write_radius(256);
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    write_radius($urandom_range(1 << 20, 4096));
                end
            endcase
            repeat (PHASE_ITEMS) send_random_detection();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== proximity_dedup_object_table.f =====
src/pdot_pkg.sv
src/pdot_store.sv
src/proximity_dedup_object_table.sv
src/pdot_checker.sv
tb/dedup_table_checker.sv
tb/tb_top.sv
